/* src/bws_pkg.sv */
package bws_pkg;

  // Default sizing of the block
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_WINDOW_DEF = 32;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  // Frame height limit and counter width
  localparam int unsigned ROW_LIMIT = 1024;
  localparam int unsigned ROW_W     = 10;

  // Fixed field widths
  localparam int unsigned PIXEL_W  = 16;
  localparam int unsigned SUM_OUT_W = 26;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned HEIGHT_W = 11;

  // Stream packing: window_sum, out_row, out_col, padded to bytes
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 48;

  // Reset values of the registers
  localparam int unsigned WIDTH_RST  = 1024;
  localparam int unsigned HEIGHT_RST = 1024;
  localparam int unsigned WINDOW_RST = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_WINDOW_SIZE  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic                 frame_last;
    logic [POS_W-1:0]     out_col;
    logic [POS_W-1:0]     out_row;
    logic [SUM_OUT_W-1:0] window_sum;
  } result_t;

  function automatic int unsigned max1(input int unsigned v);
    return (v < 1) ? 1 : v;
  endfunction

  function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

endpackage

/* src/box_window_sum_top.sv */
// K by K box sum over a raster-order pixel stream.
// Slave stream s_axis_* carries one pixel per item, row by row, left to right.
// Master stream m_axis_* carries one item for each K by K window that lies
// wholly inside the frame, issued when the window's bottom-right pixel
// arrives; tlast marks the last window of the frame. No windows come out
// when K exceeds the frame width or height.
// The cfg_* channel writes image width, image height and window size (index
// 0, 1, 2); any such write restarts the frame. It is always ready; the user
// must write it only while no item is in flight, which the block does not enforce.
// A pixel's column-sum and history memory reads are registered with it into
// stage 1, where the add/subtract forms the result that is written into the
// output queue. Throughput is one pixel per cycle while s_axis_tready is high,
// set by the single read/write port pair on each memory, with a one-deep
// bypass covering back-to-back hits on the same entry.
// A four-entry output queue parts the two sides: s_axis_tready only drops
// when a stalled receiver lets the queue entries plus a pixel in stage 1 reach its depth.
// Reset clears counters, the queue and the registers to width 1024,
// height 1024, window 3. Memories need no clearing: every entry whose read
// value is used in a frame has been written earlier in that frame.
module box_window_sum_top #(
  parameter int unsigned MAX_WIDTH  = bws_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_WINDOW = bws_pkg::MAX_WINDOW_DEF,
  parameter int unsigned PIXEL_BITS = bws_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bws_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // pixel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bws_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // window_sum, out_row, out_col
  output logic                                m_axis_tlast,   // frame_last
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bws_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bws_pkg::CFG_W-1:0]           cfg_data_i
);

  // pixel bits in use, never more than the input field carries
  localparam int unsigned PIX_W = bws_pkg::min_u(PIXEL_BITS, bws_pkg::PIXEL_W);
  localparam int unsigned CW    = bws_pkg::max1($clog2(MAX_WIDTH));
  localparam int unsigned KW    = bws_pkg::max1($clog2(MAX_WINDOW));
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned KRW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned HW    = bws_pkg::HEIGHT_W;
  localparam int unsigned RW    = bws_pkg::ROW_W;
  localparam int unsigned CS_W  = PIX_W + $clog2(MAX_WINDOW);
  localparam int unsigned SUM_W = PIX_W + 2 * $clog2(MAX_WINDOW);
  localparam int unsigned HIST_DEPTH = 2 ** (KW + CW);
  localparam int unsigned COL_DEPTH  = 2 ** CW;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned QPW = $clog2(Q_DEPTH);
  localparam int unsigned W_RST = bws_pkg::min_u(bws_pkg::WIDTH_RST, MAX_WIDTH);
  localparam int unsigned K_RST = bws_pkg::min_u(bws_pkg::WINDOW_RST, MAX_WINDOW);

  // ---------------- configuration ----------------
  logic [WW-1:0]  width_q;
  logic [HW-1:0]  height_q;
  logic [KRW-1:0] win_q;
  logic           cfg_hit;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bws_pkg::REG_IMAGE_WIDTH,
        bws_pkg::REG_IMAGE_HEIGHT,
        bws_pkg::REG_WINDOW_SIZE: cfg_hit = 1'b1;
        default:                  cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(W_RST);
      height_q <= HW'(bws_pkg::HEIGHT_RST);
      win_q    <= KRW'(K_RST);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bws_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_data_i == '0) width_q <= WW'(1);
          else if (cfg_data_i > MAX_WIDTH) width_q <= WW'(MAX_WIDTH);
          else width_q <= WW'(cfg_data_i);
        end
        bws_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_data_i == '0) height_q <= HW'(1);
          else if (cfg_data_i > bws_pkg::ROW_LIMIT) height_q <= HW'(bws_pkg::ROW_LIMIT);
          else height_q <= HW'(cfg_data_i);
        end
        bws_pkg::REG_WINDOW_SIZE: begin
          if (cfg_data_i[5:0] == '0) win_q <= KRW'(1);
          else if (cfg_data_i[5:0] > MAX_WINDOW) win_q <= KRW'(MAX_WINDOW);
          else win_q <= KRW'(cfg_data_i[5:0]);
        end
        default: ;
      endcase
    end
  end

  // ---------------- position counters ----------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [KW-1:0] hrow_q;   // row modulo K, selects the history bank
  logic          in_acc;
  logic          col_end, row_end, hrow_end;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign col_end  = (WW'(col_q) == width_q - WW'(1));
  assign row_end  = (HW'(row_q) == height_q - HW'(1));
  assign hrow_end = (KRW'(hrow_q) == win_q - KRW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      hrow_q <= '0;
    end else if (cfg_hit) begin
      col_q  <= '0;
      row_q  <= '0;
      hrow_q <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        col_q <= '0;
        if (row_end) begin
          row_q  <= '0;
          hrow_q <= '0;
        end else begin
          row_q  <= row_q + RW'(1);
          hrow_q <= hrow_end ? '0 : hrow_q + KW'(1);
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // ---------------- stage 0: classify, issue memory reads ----------------
  logic [PIX_W-1:0]      pix;
  logic [KW+CW-1:0]      hist_addr;
  logic [RW:0]           row_top;
  logic [CW:0]           col_left;
  logic                  emit;

  assign pix       = s_axis_tdata[PIX_W-1:0];
  assign hist_addr = {hrow_q, col_q};
  assign row_top   = {1'b0, row_q} + (RW+1)'(1) - (RW+1)'(win_q);
  assign col_left  = {1'b0, col_q} + (CW+1)'(1) - (CW+1)'(win_q);
  assign emit = (WW'(win_q) <= width_q) && (HW'(win_q) <= height_q)
             && ({1'b0, row_q} + (RW+1)'(1) >= (RW+1)'(win_q))
             && ({1'b0, col_q} + (CW+1)'(1) >= (CW+1)'(win_q));

  logic                  s1_valid_q;
  logic [PIX_W-1:0]      s1_pix_q;
  logic [CW-1:0]         s1_col_q;
  logic [KW+CW-1:0]      s1_haddr_q;
  logic                  s1_row0_q, s1_rowk_q, s1_col0_q, s1_colk_q, s1_emit_q, s1_last_q;
  logic [bws_pkg::POS_W-1:0] s1_orow_q, s1_ocol_q;
  logic                  cs_fwd_q, hist_fwd_q;
  logic [CS_W-1:0]       cs_fwd_data_q;
  logic [PIX_W-1:0]      hist_fwd_data_q;
  logic [CS_W-1:0]       cs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q   <= pix;
      s1_col_q   <= col_q;
      s1_haddr_q <= hist_addr;
      s1_row0_q  <= (row_q == '0);
      s1_rowk_q  <= ((RW+1)'(row_q) < (RW+1)'(win_q));
      s1_col0_q  <= (col_q == '0);
      s1_colk_q  <= ((CW+1)'(col_q) < (CW+1)'(win_q));
      s1_emit_q  <= emit;
      s1_last_q  <= row_end & col_end;
      s1_orow_q  <= bws_pkg::POS_W'(row_top);
      s1_ocol_q  <= bws_pkg::POS_W'(col_left);
      // bypass: the item ahead writes the entry being read now
      cs_fwd_q        <= s1_valid_q && (s1_col_q == col_q);
      cs_fwd_data_q   <= cs;
      hist_fwd_q      <= s1_valid_q && (s1_haddr_q == hist_addr);
      hist_fwd_data_q <= s1_pix_q;
    end
  end

  // Column running sums and pixel history
  logic [CS_W-1:0]       colsum_mem [COL_DEPTH];
  logic [PIX_W-1:0]      hist_mem   [HIST_DEPTH];
  logic [CS_W-1:0]       colsum_rd_q;
  logic [PIX_W-1:0]      hist_rd_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) colsum_mem[s1_col_q] <= cs;
    if (in_acc) colsum_rd_q <= colsum_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) hist_mem[s1_haddr_q] <= s1_pix_q;
    if (in_acc) hist_rd_q <= hist_mem[hist_addr];
  end

  // ---------------- stage 1: vertical and horizontal sums ----------------
  logic [CS_W-1:0]       colsum_prev;
  logic [PIX_W-1:0]      hist_old;
  logic [CS_W-1:0]       dly_q [MAX_WINDOW];
  logic [CS_W-1:0]       dly_tap;
  logic [SUM_W-1:0]      rsum_q, rsum_d;
  logic [KW-1:0]         tap_idx;

  assign colsum_prev = cs_fwd_q ? cs_fwd_data_q : colsum_rd_q;
  assign hist_old    = hist_fwd_q ? hist_fwd_data_q : hist_rd_q;
  assign tap_idx     = KW'(win_q - KRW'(1));
  assign dly_tap     = dly_q[tap_idx];

  always_comb begin
    if (s1_row0_q) cs = CS_W'(s1_pix_q);
    else if (s1_rowk_q) cs = colsum_prev + CS_W'(s1_pix_q);
    else cs = colsum_prev + CS_W'(s1_pix_q) - CS_W'(hist_old);
  end

  always_comb begin
    if (s1_col0_q) rsum_d = SUM_W'(cs);
    else if (s1_colk_q) rsum_d = rsum_q + SUM_W'(cs);
    else rsum_d = rsum_q + SUM_W'(cs) - SUM_W'(dly_tap);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsum_q <= '0;
    end else if (s1_valid_q) begin
      rsum_q <= rsum_d;
    end
  end

  // last MAX_WINDOW column sums, tapped at K-1
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      dly_q[0] <= cs;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  // ---------------- output queue ----------------
  bws_pkg::result_t res;
  bws_pkg::result_t q_mem [Q_DEPTH];
  logic [QPW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPW:0]     cnt_q;
  logic             push, pop;

  assign res.window_sum = bws_pkg::SUM_OUT_W'(rsum_d);
  assign res.out_row    = s1_orow_q;
  assign res.out_col    = s1_ocol_q;
  assign res.frame_last = s1_last_q;

  assign push = s1_valid_q & s1_emit_q;
  assign pop  = m_axis_tvalid & m_axis_tready;

  assign s_axis_tready = ((QPW+1)'(cnt_q) + (QPW+1)'(s1_valid_q)) < (QPW+1)'(Q_DEPTH);
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {2'b00, q_mem[rd_ptr_q].out_col, q_mem[rd_ptr_q].out_row,
                          q_mem[rd_ptr_q].window_sum};
  assign m_axis_tlast  = q_mem[rd_ptr_q].frame_last;

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPW'(1);
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + (QPW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
